FILE: rtl/assert_macros.svh
// Assertion macros included by the core top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: rtl/sdf_pkg.sv
// Shared constants, types and functions of the signed decimal field formatter.
package sdf_pkg;

    localparam int MAX_DIGITS    = 10;
    localparam int VALUE_W       = 32;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = MAX_DIGITS * DIGIT_W;
    localparam int POS_W         = $clog2(MAX_DIGITS);
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W         = $clog2(CONV_STEPS);
    localparam int CHAR_W        = 7;
    localparam int WIDTH_W       = 4;
    localparam int Q_DEPTH       = 2;
    localparam int QPTR_W        = $clog2(Q_DEPTH);
    localparam int QCNT_W        = $clog2(Q_DEPTH + 1);
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam int REG_FIELD_WIDTH = 0;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd6;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'h2D;

    typedef struct packed {
        logic [BCD_W-1:0] digits;
        logic             neg;
    } sdf_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } sdf_qstat_t;

    // one double-dabble step: add-3 correction, then shift in one bit
    function automatic logic [BCD_W-1:0] dabble_shift(input logic [BCD_W-1:0] bcd,
                                                      input logic bit_in);
        logic [BCD_W-1:0] t;
        t = bcd;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (t[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                t[d*DIGIT_W +: DIGIT_W] = t[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
        end
        return {t[BCD_W-2:0], bit_in};
    endfunction

    // index of the first character position, width clamped to 1..MAX_DIGITS
    function automatic logic [POS_W-1:0] top_index(input logic [WIDTH_W-1:0] w);
        logic [POS_W-1:0] r;
        if (w == '0)
            r = '0;
        else if (int'(w) > MAX_DIGITS)
            r = POS_W'(MAX_DIGITS - 1);
        else
            r = POS_W'(w - 1'b1);
        return r;
    endfunction

endpackage

FILE: rtl/sdf_front.sv
// Front end: accepts a value, takes its magnitude and converts it to BCD digits.
module sdf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [sdf_pkg::VALUE_W-1:0] value,
    output logic                            busy,
    input  sdf_pkg::sdf_qstat_t             q_stat,
    output logic                            q_push,
    output sdf_pkg::sdf_entry_t             q_data
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_DONE = 3'b100
    } front_state_t;

    front_state_t                    state_reg, state_next;
    logic [sdf_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [sdf_pkg::VALUE_W-1:0]     sh_reg, sh_next;
    logic [sdf_pkg::BCD_W-1:0]       bcd_reg, bcd_next;
    logic                            neg_reg, neg_next;
    logic [sdf_pkg::VALUE_W-1:0]     uval;

    assign uval = value;
    assign busy = (state_reg != F_IDLE);
    assign q_push = (state_reg == F_DONE) && !q_stat.full;
    assign q_data.digits = bcd_reg;
    assign q_data.neg = neg_reg;

    always_comb
    begin
        logic [sdf_pkg::BCD_W-1:0]   t;
        logic [sdf_pkg::VALUE_W-1:0] s;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        t = bcd_reg;
        s = sh_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    neg_next   = uval[sdf_pkg::VALUE_W-1];
                    sh_next    = uval[sdf_pkg::VALUE_W-1] ? (~uval + 1'b1) : uval;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                for (int i = 0; i < sdf_pkg::BITS_PER_STEP; i++)
                begin
                    t = sdf_pkg::dabble_shift(t, s[sdf_pkg::VALUE_W-1]);
                    s = {s[sdf_pkg::VALUE_W-2:0], 1'b0};
                end
                bcd_next = t;
                sh_next  = s;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == sdf_pkg::CNT_W'(sdf_pkg::CONV_STEPS - 1))
                    state_next = F_DONE;
            end
            F_DONE:
            begin
                if (!q_stat.full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

FILE: rtl/sdf_queue.sv
// Two-entry queue of converted digit sets between front and back ends.
module sdf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sdf_pkg::sdf_entry_t push_data,
    input  logic                pop,
    output sdf_pkg::sdf_entry_t head,
    output sdf_pkg::sdf_qstat_t stat
);

    sdf_pkg::sdf_entry_t          mem_reg [sdf_pkg::Q_DEPTH];
    logic [sdf_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [sdf_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [sdf_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head = mem_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full = (count_reg == sdf_pkg::QCNT_W'(sdf_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == sdf_pkg::QPTR_W'(sdf_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == sdf_pkg::QPTR_W'(sdf_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/sdf_back.sv
// Back end: walks the field and emits one registered character per cycle while the queue is not empty.
module sdf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [sdf_pkg::WIDTH_W-1:0]  field_width,
    input  sdf_pkg::sdf_entry_t          head,
    input  sdf_pkg::sdf_qstat_t          q_stat,
    output logic                         pop,
    output logic                         strobe,
    output logic [sdf_pkg::CHAR_W-1:0]   char_code,
    output logic                         last
);

    typedef enum logic [2:0] {
        B_START = 3'b001,
        B_PAD   = 3'b010,
        B_DIG   = 3'b100
    } back_state_t;

    back_state_t                    state_reg, state_next;
    logic [sdf_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                           strobe_reg, strobe_next;
    logic [sdf_pkg::CHAR_W-1:0]     char_reg, char_next;
    logic                           last_reg, last_next;

    logic [sdf_pkg::POS_W-1:0]      top_pos, start_pos, cur_pos;
    logic                           sign_only, cur_pad, active;
    logic [sdf_pkg::DIGIT_W-1:0]    dig;

    assign top_pos   = sdf_pkg::top_index(field_width);
    assign sign_only = head.neg && (top_pos == '0);
    assign start_pos = !head.neg ? top_pos : ((top_pos == '0) ? '0 : top_pos - 1'b1);

    always_comb
    begin
        case (state_reg)
            B_START:
            begin
                cur_pos = start_pos;
                cur_pad = head.neg;
                active  = !q_stat.empty;
            end
            B_PAD:
            begin
                cur_pos = pos_reg;
                cur_pad = 1'b1;
                active  = 1'b1;
            end
            B_DIG:
            begin
                cur_pos = pos_reg;
                cur_pad = 1'b0;
                active  = 1'b1;
            end
            default:
            begin
                cur_pos = pos_reg;
                cur_pad = 1'b0;
                active  = 1'b0;
            end
        endcase
    end

    assign dig = head.digits[cur_pos*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W];

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        pop         = 1'b0;
        if (active)
        begin
            strobe_next = 1'b1;
            if (cur_pad)
            begin
                if ((cur_pos != '0) && (dig == '0))
                begin
                    char_next  = sdf_pkg::CHAR_ZERO;
                    pos_next   = cur_pos - 1'b1;
                    state_next = B_PAD;
                end
                else
                begin
                    char_next = sdf_pkg::CHAR_MINUS;
                    pos_next  = cur_pos;
                    if (sign_only)
                    begin
                        last_next  = 1'b1;
                        pop        = 1'b1;
                        state_next = B_START;
                    end
                    else
                        state_next = B_DIG;
                end
            end
            else
            begin
                char_next = sdf_pkg::CHAR_ZERO
                            + {{(sdf_pkg::CHAR_W - sdf_pkg::DIGIT_W){1'b0}}, dig};
                if (cur_pos == '0)
                begin
                    last_next  = 1'b1;
                    pop        = 1'b1;
                    state_next = B_START;
                end
                else
                begin
                    pos_next   = cur_pos - 1'b1;
                    state_next = B_DIG;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_START;
            pos_reg    <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

FILE: rtl/signed_decimal_field_formatter_core.sv
// Top level of the signed decimal field formatter: config register and datapath.
// The first character follows BCD conversion, the queue and the back-end output register.
// Front end: 4-bit-per-cycle double-dabble loop, no new value until the result is queued;
// back end: one character per cycle while the queue is not empty, width clamped to 1..10.
// Results appear for one cycle on strobe; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the queue, idles both ends, field_width = 6.
`include "assert_macros.svh"
module signed_decimal_field_formatter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [sdf_pkg::VALUE_W-1:0] value,
    output logic                              busy,
    output logic                              strobe,
    output logic [sdf_pkg::CHAR_W-1:0]        char_code,
    output logic                              last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdf_pkg::ADDR_W-1:0]        paddr,
    input  logic [sdf_pkg::DATA_W-1:0]        pwdata,
    output logic [sdf_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [sdf_pkg::WIDTH_W-1:0] field_width_reg, field_width_next;
    logic                        sel_width;
    logic                        q_push, q_pop;
    sdf_pkg::sdf_entry_t         q_in, q_head;
    sdf_pkg::sdf_qstat_t         q_stat;

    assign pready = 1'b1;
    assign sel_width = (paddr[sdf_pkg::ADDR_W-1:2] ==
                        (sdf_pkg::ADDR_W - 2)'(sdf_pkg::REG_FIELD_WIDTH));

    always_comb
    begin
        field_width_next = field_width_reg;
        if (psel && penable && pwrite && sel_width)
            field_width_next = pwdata[sdf_pkg::WIDTH_W-1:0];
    end

    assign prdata = sel_width ?
                    {{(sdf_pkg::DATA_W - sdf_pkg::WIDTH_W){1'b0}}, field_width_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_width_reg <= sdf_pkg::WIDTH_RESET;
        else
            field_width_reg <= field_width_next;
    end

    sdf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .busy   (busy),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_data (q_in)
    );

    sdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    sdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_width (field_width_reg),
        .head        (q_head),
        .q_stat      (q_stat),
        .pop         (q_pop),
        .strobe      (strobe),
        .char_code   (char_code),
        .last        (last)
    );

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, q_push && q_stat.full)
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, q_pop && q_stat.empty)
    `ASSERT_IMPLY(a_last_with_strobe, clk, rst_n, last, strobe)
    `ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for signed_decimal_field_formatter_core: directed table, then random values.
`timescale 1ns / 100ps

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_ROWS = 21;
    localparam int ITEMS_PER_SEG = 50;

    typedef struct {
        logic [sdf_pkg::CHAR_W-1:0] code;
        logic                       last;
    } field_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [sdf_pkg::VALUE_W-1:0] value = '0;
    logic busy;
    logic strobe;
    logic [sdf_pkg::CHAR_W-1:0] char_code;
    logic last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sdf_pkg::ADDR_W-1:0] paddr = '0;
    logic [sdf_pkg::DATA_W-1:0] pwdata = '0;
    logic [sdf_pkg::DATA_W-1:0] prdata;
    logic pready;

    field_char_t pending_chars[$];
    logic [sdf_pkg::WIDTH_W-1:0] width_reg = sdf_pkg::WIDTH_RESET;
    int errors = 0;
    int stall_cycles = 0;

    // directed table: width, value, field text ("" = use predictor)
    logic [3:0] row_width [NUM_ROWS] = '{
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
        4'd1, 4'd1, 4'd1, 4'd1,
        4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
        4'd0, 4'd0,
        4'd15, 4'd15
    };
    logic [31:0] row_value [NUM_ROWS] = '{
        32'd0, -32'sd12, 32'd12, 32'd2147483647, -32'sd2147483647, 32'd1, -32'sd1,
        -32'sd5, 32'd7, 32'd0, 32'd123,
        32'd2147483647, -32'sd2147483647, 32'd0, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd9, -32'sd3,
        32'd42, -32'sd42
    };
    string row_text [NUM_ROWS] = '{
        "000000", "000-12", "000012", "483647", "-83647", "000001", "0000-1",
        "-", "7", "0", "3",
        "2147483647", "-147483647", "0000000000", "-147483648", "", "",
        "9", "-",
        "0000000042", "0000000-42"
    };

    signed_decimal_field_formatter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void push_char(input logic [sdf_pkg::CHAR_W-1:0] code, input logic fin);
        field_char_t c;
        c.code = code;
        c.last = fin;
        pending_chars.push_back(c);
    endfunction

    // characters of one formatted field, most significant first
    function automatic void field_chars(input logic [31:0] v, input logic [3:0] fw);
        logic neg;
        logic [32:0] mag;
        logic [3:0] digs [sdf_pkg::MAX_DIGITS];
        int w;
        int p;
        int n;
        neg = v[31];
        mag = neg ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        for (int k = 0; k < sdf_pkg::MAX_DIGITS; k++)
        begin
            digs[k] = 4'(mag % 10);
            mag = mag / 10;
        end
        w = int'(fw);
        if (w < 1)
            w = 1;
        if (w > sdf_pkg::MAX_DIGITS)
            w = sdf_pkg::MAX_DIGITS;
        p = w - 1 - (neg ? 1 : 0);
        n = 0;
        while (p > 0 && digs[p] == 0)
        begin
            push_char(sdf_pkg::CHAR_ZERO, n == w - 1);
            n++;
            p--;
        end
        if (neg)
        begin
            push_char(sdf_pkg::CHAR_MINUS, n == w - 1);
            n++;
        end
        while (p >= 0)
        begin
            push_char(sdf_pkg::CHAR_ZERO + 7'(digs[p]), n == w - 1);
            n++;
            p--;
        end
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        longint p;
        int k;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 999);
            2:
            begin
                k = $urandom_range(0, 9);
                p = 1;
                repeat (k) p = p * 10;
                v = 32'(p * $urandom_range(1, 2) + $urandom_range(0, 2) - 1);
            end
            3: v = $urandom_range(0, 99999);
            4:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'd0;
                    1: v = 32'd1;
                    2: v = 32'd2147483647;
                    3: v = 32'h8000_0000;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: v = {1'b0, 31'($urandom)};
        endcase
        if (v != 32'h8000_0000 && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    // one transaction on the command port; expectations are queued on acceptance
    task automatic send_value(input logic [31:0] v, input string text, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        if (text.len() == 0)
            field_chars(v, width_reg);
        else
            for (int j = 0; j < text.len(); j++)
                push_char(7'(text[j]), j == text.len() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width(input logic [3:0] w);
        logic [31:0] data;
        drain();
        data = $urandom;
        data[3:0] = w;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= sdf_pkg::ADDR_W'(sdf_pkg::REG_FIELD_WIDTH * 4);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        width_reg = data[3:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_chars
        field_char_t want;
        if (rst_n && strobe)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("char_code %0h arrived with no transaction pending", char_code);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (char_code !== want.code)
                begin
                    $error("char_code: expected %0h, got %0h", want.code, char_code);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("signed_decimal_field_formatter_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        int idle_pct [3];
        logic [3:0] w;
        idle_pct = '{11, 67, 0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (row_width[i] != width_reg)
                write_width(row_width[i]);
            send_value(row_value[i], row_text[i], 11);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int seg = 0; seg < 3; seg++)
            begin
                case (seg)
                    0: w = (ph == 1) ? 4'd1 : 4'd10;
                    1: w = 4'($urandom_range(0, 15));
                    default: w = 4'($urandom_range(1, 4));
                endcase
                write_width(w);
                for (int n = 0; n < ITEMS_PER_SEG; n++)
                    send_value(pick_value(), "", idle_pct[ph]);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_chars.size() == 0)
            $display("signed_decimal_field_formatter_core regression: pass");
        else
            $display("signed_decimal_field_formatter_core regression: fail");
        $finish;
    end

endmodule
